### rtl/core/kvp_pkg.sv
// Shared types and constants for the key-value record stream parser.
package kvp_pkg;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_KEYLEN  = 3'd1,
    PH_KEY     = 3'd2,
    PH_VLEN_LO = 3'd3,
    PH_VLEN_HI = 3'd4,
    PH_VALUE   = 3'd5,
    PH_DONE    = 3'd6,
    PH_FAILED  = 3'd7
  } phase_e;

  typedef enum logic [2:0] {
    ERR_NONE         = 3'd0,
    ERR_HEADER_SHORT = 3'd1,
    ERR_BAD_MAGIC    = 3'd2,
    ERR_BAD_VERSION  = 3'd3,
    ERR_TRUNCATED    = 3'd4
  } err_e;

  typedef enum logic [1:0] {
    OK_KEY    = 2'd0,
    OK_VALUE  = 2'd1,
    OK_EMPTY  = 2'd2,
    OK_STATUS = 2'd3
  } okind_e;

  localparam logic       IN_KIND_DATA   = 1'b0;
  localparam logic       IN_KIND_END    = 1'b1;
  localparam logic [2:0] HEADER_BYTES   = 3'd7;
  localparam logic [2:0] MAGIC_BYTES    = 3'd4;
  localparam logic [2:0] VERSION_POS    = 3'd4;
  localparam logic [2:0] COUNT_LO_POS   = 3'd5;
  localparam logic [31:0] MAGIC_RESET   = 32'h564B_4C45;
  localparam logic [7:0]  VERSION_RESET = 8'd1;

  localparam logic ADDR_MAGIC   = 1'b0;
  localparam logic ADDR_VERSION = 1'b1;

  typedef struct packed {
    okind_e      out_kind;
    logic [7:0]  out_byte;
    logic        last_value_byte;
    logic [15:0] record_index;
    logic        status_ok;
    err_e        error_reason;
  } res_t;

endpackage

### rtl/core/kv_record_stream_parser.sv
// Top level of the key-value record stream parser: beat registers and APB registers.
//
//   channel | signals                                   | direction
//   in      | in_valid_i, in_ready_o, kind_i, data_byte_i | sink
//   out     | out_valid_o, out_ready_i, out_kind_o ..     | source
//   apb     | psel, penable, pwrite, paddr, pwdata, prdata, pready | slave
//
// One beat per cycle sustained while the output is not stalled; a beat is held in the
// input register, then its result, if it has one, in the result register.
// Reset clears the parse state, sets magic and version to their defaults.
// A stalled output holds the result register; the input register still takes
// a beat while the output waits, then in_ready_o drops until the result moves.
module kv_record_stream_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  out_kind_o,
  output logic [7:0]  out_byte_o,
  output logic        last_value_byte_o,
  output logic [15:0] record_index_o,
  output logic        status_ok_o,
  output logic [2:0]  error_reason_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import kvp_pkg::*;

  logic        in_vld_q;
  logic        in_kind_q;
  logic [7:0]  in_byte_q;
  logic        out_vld_q;
  res_t        out_q;
  logic        advance;
  logic        step;
  logic        res_valid;
  res_t        res;
  logic [31:0] magic_q;
  logic [7:0]  version_q;
  logic        cfg_wr;

  assign advance    = !out_vld_q || out_ready_i;
  assign in_ready_o = !in_vld_q || advance;
  assign step       = in_vld_q && advance;

  kvp_parser_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (step),
    .kind_i           (in_kind_q),
    .data_byte_i      (in_byte_q),
    .magic_word_i     (magic_q),
    .format_version_i (version_q),
    .res_valid_o      (res_valid),
    .res_o            (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_kind_q <= kind_i;
      in_byte_q <= data_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign out_kind_o        = out_q.out_kind;
  assign out_byte_o        = out_q.out_byte;
  assign last_value_byte_o = out_q.last_value_byte;
  assign record_index_o    = out_q.record_index;
  assign status_ok_o       = out_q.status_ok;
  assign error_reason_o    = out_q.error_reason;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q   <= MAGIC_RESET;
      version_q <= VERSION_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        ADDR_MAGIC:   magic_q   <= pwdata;
        ADDR_VERSION: version_q <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      ADDR_MAGIC:   prdata = magic_q;
      ADDR_VERSION: prdata = {24'd0, version_q};
      default:      prdata = '0;
    endcase
  end

  a_step_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_ready_i) |=> $stable(out_q))
    else $error("result register changed while stalled");

  a_in_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !advance) |=> (in_vld_q && $stable(in_byte_q) && $stable(in_kind_q)))
    else $error("input register lost a beat while blocked");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_vld_q) |-> in_ready_o)
    else $error("input not ready with empty input register");

endmodule

### rtl/core/kvp_parser_core.sv
// Parse state and per-beat decode of the key-value image.
module kvp_parser_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic          kind_i,
  input  logic [7:0]    data_byte_i,
  input  logic [31:0]   magic_word_i,
  input  logic [7:0]    format_version_i,
  output logic          res_valid_o,
  output kvp_pkg::res_t res_o
);
  import kvp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [2:0]  pos_q, pos_d;
  logic [15:0] exp_q, exp_d;
  logic [15:0] done_q, done_d;
  logic [7:0]  key_left_q, key_left_d;
  logic [7:0]  low_q, low_d;
  logic [15:0] val_left_q, val_left_d;
  err_e        err_q, err_d;
  logic [7:0]  want_byte;
  logic [15:0] done_inc;
  logic [15:0] vlen;

  assign want_byte = magic_word_i[{pos_q[1:0], 3'b000} +: 8];
  assign done_inc  = done_q + 16'd1;
  assign vlen      = {data_byte_i, low_q};

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    exp_d      = exp_q;
    done_d     = done_q;
    key_left_d = key_left_q;
    low_d      = low_q;
    val_left_d = val_left_q;
    err_d      = err_q;
    if (step_i) begin
      if (kind_i == IN_KIND_END) begin
        phase_d    = PH_HEADER;
        pos_d      = '0;
        exp_d      = '0;
        done_d     = '0;
        key_left_d = '0;
        low_d      = '0;
        val_left_d = '0;
        err_d      = ERR_NONE;
      end else begin
        unique case (phase_q)
          PH_HEADER: begin
            if (pos_q < MAGIC_BYTES) begin
              if (data_byte_i != want_byte && err_q == ERR_NONE) err_d = ERR_BAD_MAGIC;
            end else if (pos_q == VERSION_POS) begin
              if (data_byte_i != format_version_i && err_q == ERR_NONE) err_d = ERR_BAD_VERSION;
            end else if (pos_q == COUNT_LO_POS) begin
              low_d = data_byte_i;
            end else begin
              exp_d = {data_byte_i, low_q};
            end
            pos_d = pos_q + 3'd1;
            if (pos_d == HEADER_BYTES) begin
              if (err_d != ERR_NONE) phase_d = PH_FAILED;
              else if (exp_d == '0)  phase_d = PH_DONE;
              else                   phase_d = PH_KEYLEN;
            end
          end
          PH_KEYLEN: begin
            key_left_d = data_byte_i;
            phase_d    = (data_byte_i == '0) ? PH_VLEN_LO : PH_KEY;
          end
          PH_KEY: begin
            key_left_d = key_left_q - 8'd1;
            if (key_left_d == '0) phase_d = PH_VLEN_LO;
          end
          PH_VLEN_LO: begin
            low_d   = data_byte_i;
            phase_d = PH_VLEN_HI;
          end
          PH_VLEN_HI: begin
            val_left_d = vlen;
            if (vlen == '0) begin
              done_d  = done_inc;
              phase_d = (done_inc == exp_q) ? PH_DONE : PH_KEYLEN;
            end else begin
              phase_d = PH_VALUE;
            end
          end
          PH_VALUE: begin
            val_left_d = val_left_q - 16'd1;
            if (val_left_q == 16'd1) begin
              done_d  = done_inc;
              phase_d = (done_inc == exp_q) ? PH_DONE : PH_KEYLEN;
            end
          end
          PH_DONE, PH_FAILED: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '0;
    if (step_i) begin
      if (kind_i == IN_KIND_END) begin
        res_valid_o       = 1'b1;
        res_o.out_kind    = OK_STATUS;
        if (phase_q == PH_HEADER) begin
          res_o.error_reason = ERR_HEADER_SHORT;
        end else if (err_q != ERR_NONE) begin
          res_o.error_reason = err_q;
        end else if (phase_q == PH_DONE) begin
          res_o.status_ok    = 1'b1;
          res_o.error_reason = ERR_NONE;
        end else begin
          res_o.error_reason = ERR_TRUNCATED;
        end
      end else begin
        unique case (phase_q)
          PH_KEY: begin
            res_valid_o        = 1'b1;
            res_o.out_kind     = OK_KEY;
            res_o.out_byte     = data_byte_i;
            res_o.record_index = done_q;
          end
          PH_VLEN_HI: begin
            if (vlen == '0) begin
              res_valid_o        = 1'b1;
              res_o.out_kind     = OK_EMPTY;
              res_o.record_index = done_q;
            end
          end
          PH_VALUE: begin
            res_valid_o           = 1'b1;
            res_o.out_kind        = OK_VALUE;
            res_o.out_byte        = data_byte_i;
            res_o.last_value_byte = (val_left_q == 16'd1);
            res_o.record_index    = done_q;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      pos_q      <= '0;
      exp_q      <= '0;
      done_q     <= '0;
      key_left_q <= '0;
      low_q      <= '0;
      val_left_q <= '0;
      err_q      <= ERR_NONE;
    end else begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      exp_q      <= exp_d;
      done_q     <= done_d;
      key_left_q <= key_left_d;
      low_q      <= low_d;
      val_left_q <= val_left_d;
      err_q      <= err_d;
    end
  end

  a_header_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_HEADER) |-> (pos_q == HEADER_BYTES))
    else $error("parse left header phase before seven header bytes");

  a_value_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_VALUE) |-> (val_left_q != '0))
    else $error("value phase with no bytes left");

  a_key_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_KEY) |-> (key_left_q != '0))
    else $error("key phase with no bytes left");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && kind_i == IN_KIND_END) |=> (phase_q == PH_HEADER && done_q == '0))
    else $error("end of buffer did not restart the parse");

  a_status_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.out_kind == OK_STATUS) |->
      (res_o.status_ok == (res_o.error_reason == ERR_NONE)))
    else $error("status flag disagrees with reason");

endmodule

### tb/sv/kvp_result_tracker.sv
// Result tracker for the key-value record stream parser: predicts each beat, checks each result.
`timescale 1ns / 1ps
package kvp_tb_pkg;
  import kvp_pkg::*;

  class kvp_result_tracker;
    logic [31:0] magic;
    logic [7:0]  version;

    phase_e      phase;
    logic [2:0]  hdr_pos;
    logic [15:0] rec_total;
    logic [15:0] rec_done;
    logic [7:0]  key_left;
    logic [7:0]  len_lo;
    logic [15:0] val_left;
    err_e        err;

    res_t        expected_results[$];
    int unsigned mismatches;

    function new();
      magic      = MAGIC_RESET;
      version    = VERSION_RESET;
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      phase     = PH_HEADER;
      hdr_pos   = '0;
      rec_total = '0;
      rec_done  = '0;
      key_left  = '0;
      len_lo    = '0;
      val_left  = '0;
      err       = ERR_NONE;
    endfunction

    function void write_reg(logic idx, logic [31:0] value);
      if (idx == ADDR_MAGIC) begin
        magic = value;
      end else begin
        version = value[7:0];
      end
    endfunction

    function void push(okind_e kind, logic [7:0] b, logic last, logic [15:0] idx, logic ok,
                       err_e reason);
      res_t want;
      want.out_kind        = kind;
      want.out_byte        = b;
      want.last_value_byte = last;
      want.record_index    = idx;
      want.status_ok       = ok;
      want.error_reason    = reason;
      expected_results.insert(expected_results.size(), want);
    endfunction

    function void close_record();
      rec_done = rec_done + 16'd1;
      if (rec_done == rec_total) begin
        phase = PH_DONE;
      end else begin
        phase = PH_KEYLEN;
      end
    endfunction

    function void note_beat(logic kind, logic [7:0] b);
      if (kind == IN_KIND_END) begin
        if (phase == PH_HEADER) begin
          push(OK_STATUS, 8'd0, 1'b0, 16'd0, 1'b0, ERR_HEADER_SHORT);
        end else if (err != ERR_NONE) begin
          push(OK_STATUS, 8'd0, 1'b0, 16'd0, 1'b0, err);
        end else if (phase == PH_DONE) begin
          push(OK_STATUS, 8'd0, 1'b0, 16'd0, 1'b1, ERR_NONE);
        end else begin
          push(OK_STATUS, 8'd0, 1'b0, 16'd0, 1'b0, ERR_TRUNCATED);
        end
        clear();
        return;
      end
      case (phase)
        PH_HEADER: begin
          if (hdr_pos < MAGIC_BYTES) begin
            if (b != magic[8*hdr_pos +: 8] && err == ERR_NONE) err = ERR_BAD_MAGIC;
          end else if (hdr_pos == VERSION_POS) begin
            if (b != version && err == ERR_NONE) err = ERR_BAD_VERSION;
          end else if (hdr_pos == COUNT_LO_POS) begin
            len_lo = b;
          end else begin
            rec_total = {b, len_lo};
          end
          hdr_pos = hdr_pos + 3'd1;
          if (hdr_pos == HEADER_BYTES) begin
            if (err != ERR_NONE) begin
              phase = PH_FAILED;
            end else if (rec_total == 16'd0) begin
              phase = PH_DONE;
            end else begin
              phase = PH_KEYLEN;
            end
          end
        end
        PH_KEYLEN: begin
          key_left = b;
          if (b == 8'd0) begin
            phase = PH_VLEN_LO;
          end else begin
            phase = PH_KEY;
          end
        end
        PH_KEY: begin
          push(OK_KEY, b, 1'b0, rec_done, 1'b0, ERR_NONE);
          key_left = key_left - 8'd1;
          if (key_left == 8'd0) phase = PH_VLEN_LO;
        end
        PH_VLEN_LO: begin
          len_lo = b;
          phase  = PH_VLEN_HI;
        end
        PH_VLEN_HI: begin
          val_left = {b, len_lo};
          if (val_left == 16'd0) begin
            push(OK_EMPTY, 8'd0, 1'b0, rec_done, 1'b0, ERR_NONE);
            close_record();
          end else begin
            phase = PH_VALUE;
          end
        end
        PH_VALUE: begin
          push(OK_VALUE, b, val_left == 16'd1, rec_done, 1'b0, ERR_NONE);
          val_left = val_left - 16'd1;
          if (val_left == 16'd0) close_record();
        end
        default: begin
        end
      endcase
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_beat(res_t got);
      res_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: result beat expected none got kind %0d byte %0d", $time,
                 got.out_kind, got.out_byte);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("out_kind", want.out_kind, got.out_kind);
      compare_field("out_byte", want.out_byte, got.out_byte);
      compare_field("last_value_byte", want.last_value_byte, got.last_value_byte);
      compare_field("record_index", want.record_index, got.record_index);
      compare_field("status_ok", want.status_ok, got.status_ok);
      compare_field("error_reason", want.error_reason, got.error_reason);
    endfunction
  endclass

endpackage

### tb/sv/tb_top.sv
// Top-level testbench for the key-value record stream parser.
`timescale 1ns / 1ps
module tb_top;
  import kvp_pkg::*;
  import kvp_tb_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 6;
  localparam int PHASE_BEATS  = 340;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        kind_i;
  logic [7:0]  data_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  out_kind_o;
  logic [7:0]  out_byte_o;
  logic        last_value_byte_o;
  logic [15:0] record_index_o;
  logic        status_ok_o;
  logic [2:0]  error_reason_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  kvp_result_tracker tracker = new();

  logic [7:0]  img[$];
  int unsigned beats;
  int unsigned send_gap_pct;
  int unsigned ready_drop_pct;
  int unsigned stall_request;
  int unsigned hold_left;
  int unsigned quiet_cycles;

  kv_record_stream_parser dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .kind_i            (kind_i),
    .data_byte_i       (data_byte_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_kind_o        (out_kind_o),
    .out_byte_o        (out_byte_o),
    .last_value_byte_o (last_value_byte_o),
    .record_index_o    (record_index_o),
    .status_ok_o       (status_ok_o),
    .error_reason_o    (error_reason_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // hold off the result channel at random, or for a requested stretch
  initial begin
    out_ready_i = 1'b0;
    hold_left   = 0;
    forever begin
      @(negedge clk_i);
      if (stall_request != 0) begin
        hold_left     = stall_request;
        stall_request = 0;
      end
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= ready_drop_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      tracker.check_beat({out_kind_o, out_byte_o, last_value_byte_o, record_index_o,
                          status_ok_o, error_reason_o});
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic offer_beat(logic kind, logic [7:0] b);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= kind;
    data_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_beat(kind, b);
    beats++;
    @(negedge clk_i);
  endtask

  task automatic send_image();
    foreach (img[i]) offer_beat(IN_KIND_DATA, img[i]);
    offer_beat(IN_KIND_END, 8'($urandom_range(0, 255)));
    img.delete();
  endtask

  task automatic append_byte(logic [7:0] b);
    img.insert(img.size(), b);
  endtask

  task automatic push_header(logic [31:0] m, logic [7:0] v, logic [15:0] n);
    for (int i = 0; i < 4; i++) append_byte(m[8*i +: 8]);
    append_byte(v);
    append_byte(n[7:0]);
    append_byte(n[15:8]);
  endtask

  task automatic push_record(int klen, int vlen);
    append_byte(8'(klen));
    repeat (klen) append_byte(8'($urandom));
    append_byte(8'(vlen));
    append_byte(8'(vlen >> 8));
    repeat (vlen) append_byte(8'($urandom));
  endtask

  // drop valid and wait out every expected result plus the no-result tail
  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (tracker.expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    tracker.write_reg(idx, value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic random_image();
    int unsigned sel;
    int unsigned cut;
    int          nrec;
    logic [31:0] m;
    logic [7:0]  v;
    logic [15:0] n;
    sel = $urandom_range(0, 99);
    if (sel < 5) begin
      repeat ($urandom_range(0, 12)) append_byte(8'($urandom));
    end else begin
      m = tracker.magic;
      v = tracker.version;
      if ($urandom_range(0, 99) < 8) begin
        cut = $urandom_range(0, 3);
        m   = m ^ (32'($urandom_range(1, 255)) << (8 * cut));
      end
      if ($urandom_range(0, 99) < 8) v = v ^ 8'($urandom_range(1, 255));
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
        n = 16'd0;
      end else if (sel < 15) begin
        n = 16'($urandom);
      end else begin
        n = 16'($urandom_range(1, 4));
      end
      push_header(m, v, n);
      nrec = (n > 16'd4) ? $urandom_range(0, 3) : int'(n);
      repeat (nrec) begin
        push_record(($urandom_range(0, 49) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 5),
                    ($urandom_range(0, 49) == 0) ? $urandom_range(6, 300) : $urandom_range(0, 5));
      end
      if ($urandom_range(0, 99) < 10) begin
        cut = $urandom_range(0, img.size() - 1);
        while (img.size() > cut) void'(img.pop_back());
      end
      if ($urandom_range(0, 99) < 10) begin
        repeat ($urandom_range(1, 6)) append_byte(8'($urandom));
      end
    end
    send_image();
  endtask

  task automatic run_phase(int unsigned gap_pct, int unsigned drop_pct, bit with_stall,
                           bit with_pause);
    int unsigned stop_at;
    int unsigned count;
    send_gap_pct   = gap_pct;
    ready_drop_pct = drop_pct;
    stop_at        = beats + PHASE_BEATS;
    count          = 0;
    while (beats < stop_at) begin
      if (with_stall && count == 3) begin
        stall_request = 300;
        push_header(tracker.magic, tracker.version, 16'd2);
        push_record(2, 12);
        push_record(1, 20);
        send_image();
      end
      if (with_pause && count == 5) quiesce();
      random_image();
      count++;
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    kind_i         = IN_KIND_DATA;
    data_byte_i    = 8'd0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = 3'd0;
    pwdata         = 32'd0;
    beats          = 0;
    stall_request  = 0;
    quiet_cycles   = 0;
    send_gap_pct   = 13;
    ready_drop_pct = 54;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // end of buffer alone, then a short header with a bad magic byte
    send_image();
    append_byte(8'h00);
    append_byte(8'h4C);
    append_byte(8'hFF);
    send_image();
    // bad version, zero records
    push_header(MAGIC_RESET, ~VERSION_RESET, 16'd0);
    send_image();
    // bad magic and bad version, bytes after the failure
    push_header(MAGIC_RESET ^ 32'hFF00_0000, 8'h00, 16'd1);
    append_byte(8'hFF);
    append_byte(8'h00);
    send_image();
    // zero records, trailing byte
    push_header(MAGIC_RESET, VERSION_RESET, 16'd0);
    append_byte(8'h01);
    send_image();
    // empty key and empty value, then one-byte key and value, trailing byte
    push_header(MAGIC_RESET, VERSION_RESET, 16'd2);
    append_byte(8'h00);
    append_byte(8'h00);
    append_byte(8'h00);
    append_byte(8'h01);
    append_byte(8'hFF);
    append_byte(8'h01);
    append_byte(8'h00);
    append_byte(8'h00);
    append_byte(8'hFF);
    send_image();
    // cut inside a key
    push_header(MAGIC_RESET, VERSION_RESET, 16'd1);
    append_byte(8'h02);
    append_byte(8'hAA);
    send_image();
    // count with only the high byte set, cut after one record
    push_header(MAGIC_RESET, VERSION_RESET, 16'h0100);
    push_record(1, 2);
    send_image();
    quiesce();

    write_reg(ADDR_MAGIC, $urandom);
    write_reg(ADDR_VERSION, 32'($urandom_range(0, 255)));
    run_phase(13, 54, 1'b1, 1'b0);
    quiesce();

    write_reg(ADDR_MAGIC, 32'h0000_0000);
    write_reg(ADDR_VERSION, 32'h0000_0000);
    run_phase(54, 13, 1'b0, 1'b1);
    quiesce();

    write_reg(ADDR_MAGIC, 32'hFFFF_FFFF);
    write_reg(ADDR_VERSION, 32'h0000_00FF);
    run_phase(0, 0, 1'b0, 1'b0);
    quiesce();

    if (tracker.expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time,
               tracker.expected_results.size());
    end
    if (tracker.mismatches == 0 && tracker.expected_results.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

### kv_record_stream_parser.f
rtl/core/kvp_pkg.sv
rtl/core/kvp_parser_core.sv
rtl/core/kv_record_stream_parser.sv
tb/sv/kvp_result_tracker.sv
tb/sv/tb_top.sv
